### src/pulse_width_baud_detector_assert.svh
// ----------------------------------------------------------------------------
// pulse width baud detector assertion macros
// immediate-implication and next-cycle-implication checks with async reset
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_BAUD_DETECTOR_ASSERT_SVH
`define PULSE_WIDTH_BAUD_DETECTOR_ASSERT_SVH

// same-cycle implication
`define PWBD_ASSERT_NOW(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("pwbd check failed");

// next-cycle implication
`define PWBD_ASSERT_NEXT(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("pwbd check failed");

`endif

### src/pwbd_pkg.sv
// ----------------------------------------------------------------------------
// pwbd_pkg
// types, widths and constants shared by the pulse width baud detector
// ----------------------------------------------------------------------------
package pwbd_pkg;

    localparam int unsigned WINDOW_DEF = 10;

    localparam int unsigned TS_W   = 32;
    localparam int unsigned SUM_W  = 38;
    localparam int unsigned S16_W  = 42;
    localparam int unsigned CNT_W  = 7;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned AVG_W  = 36;
    localparam int unsigned BAUD_W = 26;
    localparam int unsigned ERR_W  = 20;
    localparam int unsigned DEN_W  = 22;
    localparam int unsigned DVD_W  = 56;
    localparam int unsigned DVS_W  = 38;
    localparam int unsigned Q_W    = 36;
    localparam int unsigned NB_W   = 6;
    localparam int unsigned MUL_W  = 14;
    localparam int unsigned MIDX_W = 4;

    localparam logic [NB_W-1:0] NB_AVG  = 6'd42;
    localparam logic [NB_W-1:0] NB_BAUD = 6'd26;
    localparam logic [NB_W-1:0] NB_ERR  = 6'd56;

    localparam int unsigned BAUD_NUM_BASE = 1000000;
    localparam int unsigned BAUD_MAX      = 64000000;
    localparam int unsigned ERR_MAX       = 1000000;
    localparam logic [MUL_W-1:0] ERR_SCALE = 14'd10000;

    localparam logic [CFG_W-1:0] UART_RST = 16'd139;
    localparam logic [CFG_W-1:0] I2C_RST  = 16'd160;
    localparam logic [CFG_W-1:0] SPI_RST  = 16'd32;
    localparam logic [CFG_W-1:0] TOL_RST  = 16'd80;

    localparam logic REQ_FALL = 1'b0;
    localparam logic REQ_RISE = 1'b1;

    typedef enum logic [1:0] {
        CFG_UART = 2'd0,
        CFG_I2C  = 2'd1,
        CFG_SPI  = 2'd2,
        CFG_TOL  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PROTO_UART = 2'd0,
        PROTO_I2C  = 2'd1,
        PROTO_SPI  = 2'd2,
        PROTO_NONE = 2'd3
    } proto_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_CMP,
        ST_AVG,
        ST_AVG_WAIT,
        ST_BAUD,
        ST_BAUD_WAIT,
        ST_MUL,
        ST_ERR,
        ST_ERR_WAIT,
        ST_DONE
    } eng_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] expected_uart_q4;
        logic [CFG_W-1:0] expected_i2c_q4;
        logic [CFG_W-1:0] expected_spi_q4;
        logic [CFG_W-1:0] tolerance_q4;
    } cfg_t;

    typedef struct packed {
        logic            req_type;
        logic [TS_W-1:0] timestamp_us;
    } evt_t;

    typedef struct packed {
        logic [TS_W-1:0]   pulse_width_us;
        logic [CNT_W-1:0]  sample_number;
        logic              report_valid;
        logic [AVG_W-1:0]  average_bit_q4;
        logic [BAUD_W-1:0] baud_estimate;
        logic [ERR_W-1:0]  error_percent_x100;
        logic [1:0]        protocol_code;
    } rpt_t;

    typedef struct packed {
        logic [AVG_W-1:0]  avg;
        logic [BAUD_W-1:0] baud;
        logic [ERR_W-1:0]  err;
        proto_t            proto;
    } eng_rpt_t;

    typedef struct packed {
        logic busy;
        logic done;
    } eng_sts_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
        logic [NB_W-1:0]  nbits;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quotient;
        logic           ovf;
    } div_rsp_t;

endpackage

### src/pwbd_if.sv
// ----------------------------------------------------------------------------
// pwbd_if
// valid/ready channels for edge events in and measurement words out
// ----------------------------------------------------------------------------
interface pwbd_evt_if
    import pwbd_pkg::*;
();
    logic valid;
    logic ready;
    evt_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pwbd_rpt_if
    import pwbd_pkg::*;
();
    logic valid;
    logic ready;
    rpt_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/pwbd_sdiv.sv
// ----------------------------------------------------------------------------
// pwbd_sdiv
// bit-serial restoring divider, one dividend bit per cycle, msb first
// ----------------------------------------------------------------------------
module pwbd_sdiv
    import pwbd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg;
    logic             done_reg;
    logic [NB_W-1:0]  cnt_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [Q_W-1:0]   q_reg;
    logic             ovf_reg;

    logic [DVS_W:0]   rem_full;
    logic             ge;
    logic [DVS_W-1:0] rem_next;

    assign rem_full = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge       = rem_full >= {1'b0, dvs_reg};
    assign rem_next = ge ? DVS_W'(rem_full - {1'b0, dvs_reg}) : rem_full[DVS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == NB_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= {q_reg[Q_W-2:0], ge};
            ovf_reg <= ovf_reg | q_reg[Q_W-1];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;
    assign rsp.ovf      = ovf_reg;

endmodule

### src/pwbd_report.sv
// ----------------------------------------------------------------------------
// pwbd_report
// window report sequencer: class match, average, baud and error through one
// serial divider and a shift-add scaler
// ----------------------------------------------------------------------------
module pwbd_report
    import pwbd_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] sum,
    input  cfg_t             cfg,
    output eng_sts_t         sts,
    output eng_rpt_t         rpt
);

    localparam logic [DEN_W-1:0]  WinK    = DEN_W'(WINDOW);
    localparam logic [BAUD_W-1:0] BaudNum = BAUD_W'(BAUD_NUM_BASE * WINDOW);

    eng_state_t        state_reg, state_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    proto_t            k_reg, k_next;
    logic              found_reg, found_next;
    proto_t            proto_reg, proto_next;
    logic [S16_W-1:0]  adiff_reg, adiff_next;
    logic [S16_W-1:0]  ediff_reg, ediff_next;
    logic [AVG_W-1:0]  avg_reg, avg_next;
    logic [BAUD_W-1:0] baud_reg, baud_next;
    logic [ERR_W-1:0]  err_reg, err_next;
    logic [DVD_W-1:0]  prod_reg, prod_next;
    logic [DVD_W-1:0]  mcand_reg, mcand_next;
    logic [MIDX_W-1:0] bit_reg, bit_next;

    logic [S16_W-1:0]  sum16;
    logic [CFG_W-1:0]  exp_sel;
    logic [S16_W-1:0]  target;
    logic [S16_W-1:0]  tolw;
    logic [DEN_W-1:0]  den;
    logic [ERR_W-1:0]  err_sat;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    pwbd_sdiv u_sdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign sum16  = {sum_reg, 4'b0000};
    assign target = S16_W'(DEN_W'(exp_sel) * WinK);
    assign tolw   = S16_W'(DEN_W'(cfg.tolerance_q4) * WinK);
    assign den    = DEN_W'(cfg.expected_uart_q4) * WinK;
    assign err_sat = (div_rsp.ovf || div_rsp.quotient > Q_W'(ERR_MAX))
                   ? ERR_W'(ERR_MAX) : div_rsp.quotient[ERR_W-1:0];

    always_comb
    begin
        case (k_reg)
            PROTO_UART: exp_sel = cfg.expected_uart_q4;
            PROTO_I2C:  exp_sel = cfg.expected_i2c_q4;
            PROTO_SPI:  exp_sel = cfg.expected_spi_q4;
            default:    exp_sel = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        sum_next   = sum_reg;
        k_next     = k_reg;
        found_next = found_reg;
        proto_next = proto_reg;
        adiff_next = adiff_reg;
        ediff_next = ediff_reg;
        avg_next   = avg_reg;
        baud_next  = baud_reg;
        err_next   = err_reg;
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        bit_next   = bit_reg;
        div_req    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    sum_next   = sum;
                    k_next     = PROTO_UART;
                    found_next = 1'b0;
                    proto_next = PROTO_NONE;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                adiff_next = (sum16 > target) ? sum16 - target : target - sum16;
                if (k_reg == PROTO_UART)
                begin
                    ediff_next = adiff_next;
                end
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (!found_reg && adiff_reg < tolw)
                begin
                    found_next = 1'b1;
                    proto_next = k_reg;
                end
                case (k_reg)
                    PROTO_UART: k_next = PROTO_I2C;
                    PROTO_I2C:  k_next = PROTO_SPI;
                    default:    k_next = PROTO_NONE;
                endcase
                state_next = (k_reg == PROTO_SPI) ? ST_AVG : ST_DIFF;
            end
            ST_AVG:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {sum16, {(DVD_W - S16_W){1'b0}}};
                div_req.divisor  = DVS_W'(WINDOW);
                div_req.nbits    = NB_AVG;
                state_next       = ST_AVG_WAIT;
            end
            ST_AVG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = div_rsp.quotient;
                    state_next = ST_BAUD;
                end
            end
            ST_BAUD:
            begin
                if (sum_reg == '0)
                begin
                    baud_next  = BAUD_W'(BAUD_MAX);
                    prod_next  = '0;
                    mcand_next = DVD_W'(ediff_reg);
                    bit_next   = '0;
                    state_next = ST_MUL;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {BaudNum, {(DVD_W - BAUD_W){1'b0}}};
                    div_req.divisor  = sum_reg;
                    div_req.nbits    = NB_BAUD;
                    state_next       = ST_BAUD_WAIT;
                end
            end
            ST_BAUD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    baud_next  = div_rsp.quotient[BAUD_W-1:0];
                    prod_next  = '0;
                    mcand_next = DVD_W'(ediff_reg);
                    bit_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (cfg.expected_uart_q4 == '0)
                begin
                    err_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    if (ERR_SCALE[bit_reg])
                    begin
                        prod_next = prod_reg + mcand_reg;
                    end
                    mcand_next = {mcand_reg[DVD_W-2:0], 1'b0};
                    bit_next   = bit_reg + 1'b1;
                    if (bit_reg == MIDX_W'(MUL_W - 1))
                    begin
                        state_next = ST_ERR;
                    end
                end
            end
            ST_ERR:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg;
                div_req.divisor  = DVS_W'(den);
                div_req.nbits    = NB_ERR;
                state_next       = ST_ERR_WAIT;
            end
            ST_ERR_WAIT:
            begin
                if (div_rsp.done)
                begin
                    err_next   = err_sat;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        k_reg     <= k_next;
        found_reg <= found_next;
        proto_reg <= proto_next;
        adiff_reg <= adiff_next;
        ediff_reg <= ediff_next;
        avg_reg   <= avg_next;
        baud_reg  <= baud_next;
        err_reg   <= err_next;
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
        bit_reg   <= bit_next;
    end

    assign sts.busy  = state_reg != ST_IDLE;
    assign sts.done  = state_reg == ST_DONE;
    assign rpt.avg   = avg_reg;
    assign rpt.baud  = baud_reg;
    assign rpt.err   = err_reg;
    assign rpt.proto = proto_reg;

endmodule

### src/pulse_width_baud_detector.sv
// ----------------------------------------------------------------------------
// pulse_width_baud_detector
// low pulse width measurement on timestamped edges with windowed baud report
// ----------------------------------------------------------------------------
// A falling edge word arms the block; a rising edge word while armed yields
// one measurement word. A width that does not close the window is ready for
// the output register in the cycle after it is taken. A width that closes
// the window of WINDOW widths runs the report sequencer: three class
// compares, then one bit-serial divider shared by the average (42 bits), the
// baud estimate (26 bits) and the percent error (56 bits), plus a 14-step
// shift-add scaling before the error division. Edge words are accepted while
// a finished word waits at the output, but not while a measurement word is
// still being formed or is waiting for the output register.
// Configuration writes are taken at any edge with cfg_we high.
// ----------------------------------------------------------------------------
`include "pulse_width_baud_detector_assert.svh"

module pulse_width_baud_detector
    import pwbd_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  cfg_idx_t         cfg_idx,
    input  logic [CFG_W-1:0] cfg_wdata,
    pwbd_evt_if.sink         evt,
    pwbd_rpt_if.source       rpt
);

    cfg_t             cfg_reg;
    logic [TS_W-1:0]  start_reg;
    logic             armed_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             pend_reg;
    logic             pend_rep_reg;
    logic             pend_fin_reg;
    logic [TS_W-1:0]  pw_reg;
    logic [CNT_W-1:0] sn_reg;
    logic             out_valid_reg;
    rpt_t             out_data_reg;
    rpt_t             out_data_next;

    logic             evt_fire;
    logic             is_rise;
    logic             meas;
    logic [TS_W-1:0]  width;
    logic [SUM_W-1:0] sum_add;
    logic [CNT_W-1:0] cnt_inc;
    logic             win_full;
    logic             eng_start;
    logic             pend_ok;
    logic             load_out;
    eng_sts_t         eng_sts;
    eng_rpt_t         eng_rpt;

    pwbd_report #(
        .WINDOW (WINDOW)
    ) u_report (
        .clk   (clk),
        .rst_n (rst_n),
        .start (eng_start),
        .sum   (sum_add),
        .cfg   (cfg_reg),
        .sts   (eng_sts),
        .rpt   (eng_rpt)
    );

    assign evt.ready = !pend_reg;
    assign evt_fire  = evt.valid && evt.ready;
    assign is_rise   = evt.data.req_type == REQ_RISE;
    assign meas      = evt_fire && is_rise && armed_reg;
    assign width     = evt.data.timestamp_us - start_reg;
    assign sum_add   = sum_reg + SUM_W'(width);
    assign cnt_inc   = cnt_reg + 1'b1;
    assign win_full  = cnt_inc >= CNT_W'(WINDOW);
    assign eng_start = meas && win_full;
    assign pend_ok   = pend_reg && (!pend_rep_reg || pend_fin_reg);
    assign load_out  = pend_ok && (!out_valid_reg || rpt.ready);

    always_comb
    begin
        out_data_next.pulse_width_us     = pw_reg;
        out_data_next.sample_number      = sn_reg;
        out_data_next.report_valid       = pend_rep_reg;
        out_data_next.average_bit_q4     = pend_rep_reg ? eng_rpt.avg : '0;
        out_data_next.baud_estimate      = pend_rep_reg ? eng_rpt.baud : '0;
        out_data_next.error_percent_x100 = pend_rep_reg ? eng_rpt.err : '0;
        out_data_next.protocol_code      = pend_rep_reg ? eng_rpt.proto : PROTO_NONE;
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_uart_q4 <= UART_RST;
            cfg_reg.expected_i2c_q4  <= I2C_RST;
            cfg_reg.expected_spi_q4  <= SPI_RST;
            cfg_reg.tolerance_q4     <= TOL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_UART: cfg_reg.expected_uart_q4 <= cfg_wdata;
                CFG_I2C:  cfg_reg.expected_i2c_q4  <= cfg_wdata;
                CFG_SPI:  cfg_reg.expected_spi_q4  <= cfg_wdata;
                CFG_TOL:  cfg_reg.tolerance_q4     <= cfg_wdata;
                default:  cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= '0;
            armed_reg     <= 1'b0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_rep_reg  <= 1'b0;
            pend_fin_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt_fire && !is_rise)
            begin
                start_reg <= evt.data.timestamp_us;
                armed_reg <= 1'b1;
            end
            if (meas)
            begin
                armed_reg    <= 1'b0;
                pend_reg     <= 1'b1;
                pend_rep_reg <= win_full;
                sum_reg      <= win_full ? '0 : sum_add;
                cnt_reg      <= win_full ? '0 : cnt_inc;
            end
            if (eng_sts.done)
            begin
                pend_fin_reg <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                pend_reg      <= 1'b0;
                pend_rep_reg  <= 1'b0;
                pend_fin_reg  <= 1'b0;
            end
            else if (rpt.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (meas)
        begin
            pw_reg <= width;
            sn_reg <= cnt_inc;
        end
        if (load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign rpt.valid = out_valid_reg;
    assign rpt.data  = out_data_reg;

    `PWBD_ASSERT_NOW(a_eng_start_idle, clk, rst_n, eng_start, !eng_sts.busy)
    `PWBD_ASSERT_NOW(a_rpt_full_window, clk, rst_n, rpt.valid && rpt.data.report_valid, rpt.data.sample_number == CNT_W'(WINDOW))
    `PWBD_ASSERT_NOW(a_cnt_below_window, clk, rst_n, 1'b1, cnt_reg < CNT_W'(WINDOW))
    `PWBD_ASSERT_NEXT(a_fin_after_eng, clk, rst_n, eng_sts.done, pend_fin_reg && pend_rep_reg)

endmodule
